// ----- src/jpi_pkg.sv -----
// jpi_pkg: shared constants, register indexes and controller/datapath interface types
// for the joint path interpolator; no dependencies
package jpi_pkg;

  localparam int FIELD_JOINTS  = 6;
  localparam int JOINT_COUNT   = 6;
  localparam int FRACTION_BITS = 24;

  localparam int POS_W   = 32;
  localparam int DELTA_W = POS_W + 1;
  localparam int STEP_W  = 31;
  localparam int SEG_W   = 6;
  localparam int JIDX_W  = $clog2(FIELD_JOINTS);

  // shared divider: numerator holds a joint change magnitude or the largest change biased for a rounded-up step count
  localparam int DIV_W     = DELTA_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // 0.005 rad in the fixed-point format, rounded to nearest
  localparam logic [STEP_W-1:0] STEP_FLOOR =
    STEP_W'(((64'd1 << FRACTION_BITS) + 64'd100) / 64'd200);
  localparam logic [SEG_W-1:0] SEG_FLOOR = SEG_W'(2);

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(167772);
  localparam logic [SEG_W-1:0]  MIN_RESET  = SEG_W'(2);
  localparam logic [SEG_W-1:0]  MAX_RESET  = SEG_W'(63);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SEGMENTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SEGMENTS = 2'd2;

  localparam logic [JIDX_W-1:0] LAST_JOINT = JIDX_W'(JOINT_COUNT - 1);

  typedef struct packed {
    logic              load;
    logic              scan;
    logic              div_start;
    logic              div_seg;
    logic              seg_latch;
    logic              joint_latch;
    logic              emit;
    logic [JIDX_W-1:0] joint_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_point;
  } dp_status_t;

endpackage

// ----- src/joint_path_interpolator.sv -----
// joint_path_interpolator: top level of the linear joint-space path generator
// depends on jpi_pkg, jpi_ctrl, jpi_datapath (and jpi_divider below it)
//
// usage
// - a move item (six start and six goal joint positions, signed Q7.24 rad) is
//   taken at a rising edge with start high and busy low
// - busy stays high until the last path point has been loaded into the
//   output register; the next move item can be taken while that point shows
// - each path point appears for exactly one cycle with point_valid_o high;
//   the receiver cannot stall, so points come one per cycle, in index order
// - config writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) land at once and must
//   only be made while busy is low; unknown indexes are dropped
// sequence
// - a scan over the six joints for the largest joint change, then one segment-count
//   division and one division per joint on a shared restoring divider, each
//   made of start, 33 shift steps and done
// - then segments+1 points in consecutive cycles, one accumulator step per
//   joint per point
// reset
// - rst_ni clears the sequencer and the output strobe, and sets step_size,
//   min_segments and max_segments to 0.01 rad, 2 and 63
module joint_path_interpolator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cfg_we_i,
  input  logic [jpi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jpi_pkg::STEP_W-1:0]     cfg_wdata_i,
  input  logic signed [31:0]             start_j1_i,
  input  logic signed [31:0]             start_j2_i,
  input  logic signed [31:0]             start_j3_i,
  input  logic signed [31:0]             start_j4_i,
  input  logic signed [31:0]             start_j5_i,
  input  logic signed [31:0]             start_j6_i,
  input  logic signed [31:0]             goal_j1_i,
  input  logic signed [31:0]             goal_j2_i,
  input  logic signed [31:0]             goal_j3_i,
  input  logic signed [31:0]             goal_j4_i,
  input  logic signed [31:0]             goal_j5_i,
  input  logic signed [31:0]             goal_j6_i,
  output logic                           point_valid_o,
  output logic [5:0]                     point_index_o,
  output logic                           final_point_o,
  output logic signed [31:0]             pos_j1_o,
  output logic signed [31:0]             pos_j2_o,
  output logic signed [31:0]             pos_j3_o,
  output logic signed [31:0]             pos_j4_o,
  output logic signed [31:0]             pos_j5_o,
  output logic signed [31:0]             pos_j6_o
);

  jpi_pkg::ctrl_cmd_t  cmd;
  jpi_pkg::dp_status_t status;

  // joints packed as lanes, joint 1 in lane 0
  logic [jpi_pkg::FIELD_JOINTS-1:0][jpi_pkg::POS_W-1:0] start_pos;
  logic [jpi_pkg::FIELD_JOINTS-1:0][jpi_pkg::POS_W-1:0] goal_pos;
  logic [jpi_pkg::FIELD_JOINTS-1:0][jpi_pkg::POS_W-1:0] pos;

  assign start_pos = {start_j6_i, start_j5_i, start_j4_i,
                      start_j3_i, start_j2_i, start_j1_i};
  assign goal_pos  = {goal_j6_i, goal_j5_i, goal_j4_i,
                      goal_j3_i, goal_j2_i, goal_j1_i};

  // sequencer: one move at a time
  jpi_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // registers, divider, accumulators and output point register
  jpi_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_pos_i   (start_pos),
    .goal_pos_i    (goal_pos),
    .cmd_i         (cmd),
    .status_o      (status),
    .point_valid_o (point_valid_o),
    .point_index_o (point_index_o),
    .final_point_o (final_point_o),
    .pos_o         (pos)
  );

  assign pos_j1_o = pos[0];
  assign pos_j2_o = pos[1];
  assign pos_j3_o = pos[2];
  assign pos_j4_o = pos[3];
  assign pos_j5_o = pos[4];
  assign pos_j6_o = pos[5];

endmodule

// ----- src/jpi_divider.sv -----
// jpi_divider: restoring unsigned divider, one quotient bit per cycle
// depends on jpi_pkg for widths
module jpi_divider (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [jpi_pkg::DIV_W-1:0]      num_i,
  input  logic [jpi_pkg::STEP_W-1:0]     den_i,
  output logic                           done_o,
  output logic [jpi_pkg::DIV_W-1:0]      quot_o,
  output logic [jpi_pkg::STEP_W-1:0]     rem_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [jpi_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [jpi_pkg::DIV_W-1:0]     num_q, num_d;
  logic [jpi_pkg::STEP_W-1:0]    rem_q, rem_d;
  logic [jpi_pkg::STEP_W-1:0]    den_q, den_d;
  logic [jpi_pkg::STEP_W:0]      rem_sh;
  logic [jpi_pkg::STEP_W:0]      rem_sub;
  logic                          ge;

  assign rem_sh  = {rem_q, num_q[jpi_pkg::DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = jpi_pkg::DIV_CNT_W'(jpi_pkg::DIV_W);
      num_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[jpi_pkg::STEP_W-1:0] : rem_sh[jpi_pkg::STEP_W-1:0];
      num_d = {num_q[jpi_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == jpi_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;
  assign rem_o  = rem_q;

endmodule

// ----- src/jpi_datapath.sv -----
// jpi_datapath: configuration registers, joint change capture, largest-change scan,
// segment count, per-joint step accumulators and the output point register
// depends on jpi_pkg and jpi_divider
module jpi_datapath (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               cfg_we_i,
  input  logic [jpi_pkg::CFG_IDX_W-1:0]                      cfg_idx_i,
  input  logic [jpi_pkg::STEP_W-1:0]                         cfg_wdata_i,
  input  logic [jpi_pkg::FIELD_JOINTS-1:0][jpi_pkg::POS_W-1:0] start_pos_i,
  input  logic [jpi_pkg::FIELD_JOINTS-1:0][jpi_pkg::POS_W-1:0] goal_pos_i,
  input  jpi_pkg::ctrl_cmd_t                                 cmd_i,
  output jpi_pkg::dp_status_t                                status_o,
  output logic                                               point_valid_o,
  output logic [jpi_pkg::SEG_W-1:0]                          point_index_o,
  output logic                                               final_point_o,
  output logic [jpi_pkg::FIELD_JOINTS-1:0][jpi_pkg::POS_W-1:0] pos_o
);

  localparam int NJ = jpi_pkg::FIELD_JOINTS;

  logic [jpi_pkg::STEP_W-1:0] step_q;
  logic [jpi_pkg::SEG_W-1:0]  min_q;
  logic [jpi_pkg::SEG_W-1:0]  max_q;

  logic [jpi_pkg::STEP_W-1:0] step_eff;
  logic [jpi_pkg::SEG_W-1:0]  seg_lo;
  logic [jpi_pkg::SEG_W-1:0]  seg_hi;

  logic [jpi_pkg::POS_W-1:0]           start_q [NJ];
  logic [jpi_pkg::DELTA_W-1:0]         delta_q [NJ];
  logic [jpi_pkg::DELTA_W-1:0]         sel_delta;
  logic [jpi_pkg::DELTA_W-1:0]         sel_mag;
  logic [jpi_pkg::DELTA_W-1:0]         largest_q;

  logic [jpi_pkg::SEG_W-1:0] segs_q;
  logic [jpi_pkg::SEG_W-1:0] segs_d;
  logic [jpi_pkg::SEG_W-1:0] idx_q;

  logic [jpi_pkg::DELTA_W-1:0] qstep_q [NJ];
  logic [jpi_pkg::SEG_W-1:0]   rstep_q [NJ];
  logic [jpi_pkg::DELTA_W-1:0] qacc_q  [NJ];
  logic [jpi_pkg::SEG_W-1:0]   racc_q  [NJ];

  logic                         div_start;
  logic [jpi_pkg::DIV_W-1:0]    div_num;
  logic [jpi_pkg::STEP_W-1:0]   div_den;
  logic                         div_done;
  logic [jpi_pkg::DIV_W-1:0]    div_quot;
  logic [jpi_pkg::STEP_W-1:0]   div_rem;

  logic                         valid_q;
  logic [jpi_pkg::SEG_W-1:0]    oidx_q;
  logic                         ofinal_q;
  logic [NJ-1:0][jpi_pkg::POS_W-1:0] opos_q;
  logic [NJ-1:0][jpi_pkg::POS_W-1:0] pos_now;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= jpi_pkg::STEP_RESET;
      min_q  <= jpi_pkg::MIN_RESET;
      max_q  <= jpi_pkg::MAX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jpi_pkg::REG_STEP_SIZE:    step_q <= cfg_wdata_i;
        jpi_pkg::REG_MIN_SEGMENTS: min_q  <= cfg_wdata_i[jpi_pkg::SEG_W-1:0];
        jpi_pkg::REG_MAX_SEGMENTS: max_q  <= cfg_wdata_i[jpi_pkg::SEG_W-1:0];
        default: ;
      endcase
    end
  end

  assign step_eff = (step_q < jpi_pkg::STEP_FLOOR) ? jpi_pkg::STEP_FLOOR : step_q;
  assign seg_lo   = (min_q < jpi_pkg::SEG_FLOOR) ? jpi_pkg::SEG_FLOOR : min_q;
  assign seg_hi   = (max_q < seg_lo) ? seg_lo : max_q;

  // joint change magnitude at the joint the controller points at
  assign sel_delta = delta_q[cmd_i.joint_idx];
  assign sel_mag   = sel_delta[jpi_pkg::DELTA_W-1] ? (~sel_delta + 1'b1) : sel_delta;

  // divider operands: ceil(largest / step) or |delta| / segments
  assign div_start = cmd_i.div_start;
  assign div_num   = cmd_i.div_seg
                   ? (largest_q + {2'b00, step_eff} - 1'b1)
                   : sel_mag;
  assign div_den   = cmd_i.div_seg
                   ? step_eff
                   : {{(jpi_pkg::STEP_W - jpi_pkg::SEG_W){1'b0}}, segs_q};

  jpi_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // clamp the quotient into [lo, hi]
  always_comb begin
    segs_d = div_quot[jpi_pkg::SEG_W-1:0];
    if (div_quot < {{(jpi_pkg::DIV_W - jpi_pkg::SEG_W){1'b0}}, seg_lo}) begin
      segs_d = seg_lo;
    end else if (div_quot > {{(jpi_pkg::DIV_W - jpi_pkg::SEG_W){1'b0}}, seg_hi}) begin
      segs_d = seg_hi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      largest_q <= '0;
    end else if (cmd_i.scan && (sel_mag > largest_q)) begin
      largest_q <= sel_mag;
    end
    if (cmd_i.seg_latch) begin
      segs_q <= segs_d;
      idx_q  <= '0;
    end else if (cmd_i.emit) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  for (genvar j = 0; j < NJ; j++) begin : g_joint
    logic [jpi_pkg::SEG_W:0]     rsum;
    logic                        wrap;
    logic [jpi_pkg::DELTA_W-1:0] rmag;
    logic [jpi_pkg::DELTA_W:0]   off;
    logic [jpi_pkg::DELTA_W:0]   psum;

    assign rsum = {1'b0, racc_q[j]} + {1'b0, rstep_q[j]};
    assign wrap = rsum >= {1'b0, segs_q};
    // round to nearest, ties away from zero: bump when twice the remainder reaches segs
    assign rmag = qacc_q[j]
                + {{(jpi_pkg::DELTA_W - 1){1'b0}},
                   ({racc_q[j], 1'b0} >= {1'b0, segs_q})};
    assign off  = delta_q[j][jpi_pkg::DELTA_W-1] ? (~{1'b0, rmag} + 1'b1) : {1'b0, rmag};
    assign psum = {{2{start_q[j][jpi_pkg::POS_W-1]}}, start_q[j]} + off;
    assign pos_now[j] = (j < jpi_pkg::JOINT_COUNT) ? psum[jpi_pkg::POS_W-1:0] : '0;

    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        start_q[j] <= start_pos_i[j];
        delta_q[j] <= {goal_pos_i[j][jpi_pkg::POS_W-1], goal_pos_i[j]}
                    - {start_pos_i[j][jpi_pkg::POS_W-1], start_pos_i[j]};
      end
      if (cmd_i.joint_latch && (cmd_i.joint_idx == jpi_pkg::JIDX_W'(j))) begin
        qstep_q[j] <= div_quot;
        rstep_q[j] <= div_rem[jpi_pkg::SEG_W-1:0];
        qacc_q[j]  <= '0;
        racc_q[j]  <= '0;
      end else if (cmd_i.emit) begin
        if (wrap) begin
          racc_q[j] <= jpi_pkg::SEG_W'(rsum - {1'b0, segs_q});
          qacc_q[j] <= qacc_q[j] + qstep_q[j] + 1'b1;
        end else begin
          racc_q[j] <= rsum[jpi_pkg::SEG_W-1:0];
          qacc_q[j] <= qacc_q[j] + qstep_q[j];
        end
      end
    end
  end

  // output point register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      oidx_q   <= idx_q;
      ofinal_q <= (idx_q == segs_q);
      opos_q   <= pos_now;
    end
  end

  assign status_o.div_done   = div_done;
  assign status_o.last_point = (idx_q == segs_q);

  assign point_valid_o = valid_q;
  assign point_index_o = oidx_q;
  assign final_point_o = ofinal_q;
  assign pos_o         = opos_q;

endmodule

// ----- src/jpi_ctrl.sv -----
// jpi_ctrl: sequencer for one move: capture, scan, segment division, per-joint
// division and point emission; depends on jpi_pkg
module jpi_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  jpi_pkg::dp_status_t status_i,
  output jpi_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SGO   = 3'd2;
  localparam logic [2:0] S_SWAIT = 3'd3;
  localparam logic [2:0] S_JGO   = 3'd4;
  localparam logic [2:0] S_JWAIT = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic [jpi_pkg::JIDX_W-1:0]  jcnt_q, jcnt_d;

  always_comb begin
    state_d         = state_q;
    jcnt_d          = jcnt_q;
    cmd_o           = '0;
    cmd_o.joint_idx = jcnt_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          jcnt_d     = '0;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (jcnt_q == jpi_pkg::LAST_JOINT) begin
          state_d = S_SGO;
        end else begin
          jcnt_d = jcnt_q + 1'b1;
        end
      end
      S_SGO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_seg   = 1'b1;
        state_d         = S_SWAIT;
      end
      S_SWAIT: begin
        if (status_i.div_done) begin
          cmd_o.seg_latch = 1'b1;
          jcnt_d          = '0;
          state_d         = S_JGO;
        end
      end
      S_JGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_JWAIT;
      end
      S_JWAIT: begin
        if (status_i.div_done) begin
          cmd_o.joint_latch = 1'b1;
          if (jcnt_q == jpi_pkg::LAST_JOINT) begin
            state_d = S_EMIT;
          end else begin
            jcnt_d  = jcnt_q + 1'b1;
            state_d = S_JGO;
          end
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.last_point) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      jcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      jcnt_q  <= jcnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
